### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AFA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("allocator assertion failed");
`define AFA_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("allocator forbidden condition seen");
`else
`define AFA_ASSERT(lbl, clk, rstn, prop)
`define AFA_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### src/afa_pkg.sv
// ---------------------------------------------------------------------------
// afa_pkg
// Types and codes shared by the dual pool first-fit allocator.
// ---------------------------------------------------------------------------
`default_nettype none
package afa_pkg;

    typedef logic [1:0] t_status;
    typedef logic       t_alu_op;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_ZERO    = 2'd1;
    localparam t_status ST_NOSPACE = 2'd2;
    localparam t_status ST_FULL    = 2'd3;

    localparam t_alu_op ALU_ADD = 1'b0;
    localparam t_alu_op ALU_SUB = 1'b1;

    localparam logic FUNC_ALLOC = 1'b0;

    localparam logic [1:0] CFG_VPOOL = 2'd0;
    localparam logic [1:0] CFG_IPOOL = 2'd1;

    localparam logic [31:0] VPOOL_RESET = 32'd67108864;
    localparam logic [31:0] IPOOL_RESET = 32'd16777216;

endpackage
`default_nettype wire

### src/afa_mem.sv
// ---------------------------------------------------------------------------
// afa_mem
// Free list store for both pools: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module afa_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### src/afa_alu.sv
// ---------------------------------------------------------------------------
// afa_alu
// Shared adder and subtractor; carry out of a subtraction means a >= b.
// ---------------------------------------------------------------------------
`default_nettype none
module afa_alu
    import afa_pkg::*;
#(
    parameter int W = 32
) (
    input  wire t_alu_op        i_op,
    input  wire logic [W-1:0]   i_a,
    input  wire logic [W-1:0]   i_b,
    output logic      [W-1:0]   o_res,
    output logic                o_carry
);

    logic         w_sub;
    logic [W:0]   w_sum;

    assign w_sub = (i_op == ALU_SUB);
    assign w_sum = {1'b0, i_a} + {1'b0, (w_sub ? ~i_b : i_b)} + (W+1)'(w_sub);
    assign o_res   = w_sum[W-1:0];
    assign o_carry = w_sum[W];

endmodule
`default_nettype wire

### src/dual_pool_first_fit_allocator.sv
// Allocate: one scan per pool, one read a cycle, then a compaction of each
// pool's list and an append of any remainder.
// Free: each merge costs a list scan plus a compaction.
// One item at a time, set by the single list memory read port and the shared adder.
// After reset the block writes the initial pool entries in S_INIT0 and S_INIT1.
// ---------------------------------------------------------------------------
// dual_pool_first_fit_allocator
// First-fit allocator with coalescing free lists for a vertex and an index pool.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module dual_pool_first_fit_allocator
    import afa_pkg::*;
#(
    parameter int FREE_ENTRIES = 64,
    parameter int ADDR_BITS    = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_func,
    input  wire logic [31:0] i_vertex_bytes,
    input  wire logic [31:0] i_index_bytes,
    input  wire logic [31:0] i_vertex_free_at,
    input  wire logic [31:0] i_index_free_at,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_status          o_status,
    output logic      [31:0] o_vertex_offset,
    output logic      [31:0] o_index_offset,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int N  = FREE_ENTRIES;
    localparam int A  = ADDR_BITS;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int MW = IW + 1;
    localparam int DW = 2 * A;

    localparam logic [3:0] S_INIT0 = 4'd0;
    localparam logic [3:0] S_INIT1 = 4'd1;
    localparam logic [3:0] S_IDLE  = 4'd2;
    localparam logic [3:0] S_ASCAN = 4'd3;
    localparam logic [3:0] S_DROP  = 4'd4;
    localparam logic [3:0] S_AAPP  = 4'd5;
    localparam logic [3:0] S_FINIT = 4'd6;
    localparam logic [3:0] S_FCHK  = 4'd7;
    localparam logic [3:0] S_MSCAN = 4'd8;
    localparam logic [3:0] S_MRG   = 4'd9;
    localparam logic [3:0] S_MEND  = 4'd10;
    localparam logic [3:0] S_MAPP  = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    // Control state.
    logic [3:0]    r_st, n_st;
    logic          r_pool, n_pool;
    logic          r_chk, n_chk;
    logic [CW-1:0] r_cnt [2];
    logic [CW-1:0] n_cnt [2];
    logic [CW-1:0] r_i, n_i;
    logic          r_pv, n_pv;
    logic          r_ov, n_ov;

    // Payload state.
    logic          r_func, n_func;
    logic [A-1:0]  r_bytes [2];
    logic [A-1:0]  n_bytes [2];
    logic [A-1:0]  r_at [2];
    logic [A-1:0]  n_at [2];
    logic [IW-1:0] r_hidx [2];
    logic [IW-1:0] n_hidx [2];
    logic [A-1:0]  r_hoff [2];
    logic [A-1:0]  n_hoff [2];
    logic [A-1:0]  r_rem [2];
    logic [A-1:0]  n_rem [2];
    logic [IW-1:0] r_pi, n_pi;
    logic [A-1:0]  r_moff, n_moff;
    logic [A-1:0]  r_msz, n_msz;
    logic [A-1:0]  r_mend, n_mend;
    logic [A-1:0]  r_eoff, n_eoff;
    logic [A-1:0]  r_esz, n_esz;
    logic          r_left, n_left;
    t_status       r_stat, n_stat;
    logic [31:0]   r_vo, n_vo;
    logic [31:0]   r_io, n_io;
    t_status       r_ostat, n_ostat;
    logic [31:0]   r_ovo, n_ovo;
    logic [31:0]   r_oio, n_oio;

    logic          w_we;
    logic [MW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [MW-1:0] w_raddr;
    logic [DW-1:0] w_rdata;
    logic [A-1:0]  w_roff;
    logic [A-1:0]  w_rsz;
    logic [CW-1:0] w_cnt;
    logic          w_more;
    logic          w_done;
    logic          w_in_acc;
    logic          w_cfg_acc;
    logic          w_touch;
    t_alu_op       w_op;
    logic [A-1:0]  w_a;
    logic [A-1:0]  w_b;
    logic [A-1:0]  w_res;
    logic          w_carry;

    afa_mem #(
        .DEPTH (1 << MW),
        .AW    (MW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    afa_alu #(
        .W (A)
    ) u_alu (
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_res   (w_res),
        .o_carry (w_carry)
    );

    assign w_roff    = w_rdata[DW-1:A];
    assign w_rsz     = w_rdata[A-1:0];
    assign w_cnt     = r_cnt[r_pool];
    assign w_more    = (r_i < w_cnt);
    // A sweep is over once every entry has been issued and the last read seen.
    assign w_done    = !r_pv && !w_more;
    assign w_raddr   = {r_pool, r_i[IW-1:0]};
    assign w_in_acc  = i_in_valid && (r_st == S_IDLE);
    assign w_cfg_acc = i_cfg_valid && (r_st == S_IDLE);
    assign w_touch   = r_pv && ((w_res == r_moff) || (w_roff == r_mend));

    assign o_in_stall      = (r_st != S_IDLE);
    assign o_cfg_ready     = (r_st == S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_status        = r_ostat;
    assign o_vertex_offset = r_ovo;
    assign o_index_offset  = r_oio;

    always_comb begin
        n_st    = r_st;
        n_pool  = r_pool;
        n_chk   = r_chk;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_pv    = 1'b0;
        n_ov    = r_ov;
        n_func  = r_func;
        n_bytes = r_bytes;
        n_at    = r_at;
        n_hidx  = r_hidx;
        n_hoff  = r_hoff;
        n_rem   = r_rem;
        n_pi    = r_pi;
        n_moff  = r_moff;
        n_msz   = r_msz;
        n_mend  = r_mend;
        n_eoff  = r_eoff;
        n_esz   = r_esz;
        n_left  = r_left;
        n_stat  = r_stat;
        n_vo    = r_vo;
        n_io    = r_io;
        n_ostat = r_ostat;
        n_ovo   = r_ovo;
        n_oio   = r_oio;
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_op    = ALU_ADD;
        w_a     = '0;
        w_b     = '0;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        // Sweep states issue one read per cycle until the list end.
        if (r_st == S_ASCAN || r_st == S_DROP || r_st == S_FCHK || r_st == S_MSCAN) begin
            n_pv = w_more;
            n_pi = r_i[IW-1:0];
            if (w_more) begin
                n_i = r_i + CW'(1);
            end
        end

        case (r_st)
            S_INIT0: begin
                w_we    = 1'b1;
                w_waddr = {1'b0, IW'(0)};
                w_wdata = {A'(0), A'(VPOOL_RESET)};
                n_st    = S_INIT1;
            end
            S_INIT1: begin
                w_we    = 1'b1;
                w_waddr = {1'b1, IW'(0)};
                w_wdata = {A'(0), A'(IPOOL_RESET)};
                n_st    = S_IDLE;
            end
            S_IDLE: begin
                if (w_cfg_acc) begin
                    case (i_cfg_index)
                        CFG_VPOOL: begin
                            w_we     = 1'b1;
                            w_waddr  = {1'b0, IW'(0)};
                            w_wdata  = {A'(0), A'(i_cfg_data)};
                            n_cnt[0] = CW'(1);
                        end
                        CFG_IPOOL: begin
                            w_we     = 1'b1;
                            w_waddr  = {1'b1, IW'(0)};
                            w_wdata  = {A'(0), A'(i_cfg_data)};
                            n_cnt[1] = CW'(1);
                        end
                        default: begin
                        end
                    endcase
                end
                if (w_in_acc) begin
                    n_func     = i_func;
                    n_bytes[0] = A'(i_vertex_bytes);
                    n_bytes[1] = A'(i_index_bytes);
                    n_at[0]    = A'(i_vertex_free_at);
                    n_at[1]    = A'(i_index_free_at);
                    n_pool     = 1'b0;
                    n_chk      = 1'b1;
                    n_i        = '0;
                    n_vo       = '0;
                    n_io       = '0;
                    if (A'(i_vertex_bytes) == '0 || A'(i_index_bytes) == '0) begin
                        n_stat = ST_ZERO;
                        n_st   = S_FIN;
                    end else if (i_func == FUNC_ALLOC) begin
                        n_st = S_ASCAN;
                    end else begin
                        n_st = S_FINIT;
                    end
                end
            end
            S_ASCAN: begin
                w_op = ALU_SUB;
                w_a  = w_rsz;
                w_b  = r_bytes[r_pool];
                if (r_pv && w_carry) begin
                    n_hidx[r_pool] = r_pi;
                    n_hoff[r_pool] = w_roff;
                    n_rem[r_pool]  = w_res;
                    n_pv           = 1'b0;
                    if (!r_pool) begin
                        n_pool = 1'b1;
                        n_i    = '0;
                    end else begin
                        n_pool = 1'b0;
                        n_i    = CW'(r_hidx[0]) + CW'(1);
                        n_st   = S_DROP;
                    end
                end else if (w_done) begin
                    n_stat = ST_NOSPACE;
                    n_st   = S_FIN;
                end
            end
            S_DROP: begin
                // Close the gap left by the removed entry, keeping list order.
                if (r_pv) begin
                    w_we    = 1'b1;
                    w_waddr = {r_pool, r_pi - IW'(1)};
                    w_wdata = w_rdata;
                end
                if (w_done) begin
                    n_cnt[r_pool] = w_cnt - CW'(1);
                    if (r_func == FUNC_ALLOC) begin
                        n_st = S_AAPP;
                    end else begin
                        n_i  = '0;
                        n_st = S_MSCAN;
                    end
                end
            end
            S_AAPP: begin
                w_a = r_hoff[r_pool];
                w_b = r_bytes[r_pool];
                if (r_rem[r_pool] != '0) begin
                    w_we          = 1'b1;
                    w_waddr       = {r_pool, w_cnt[IW-1:0]};
                    w_wdata       = {w_res, r_rem[r_pool]};
                    n_cnt[r_pool] = w_cnt + CW'(1);
                end
                if (!r_pool) begin
                    n_pool = 1'b1;
                    n_i    = CW'(r_hidx[1]) + CW'(1);
                    n_st   = S_DROP;
                end else begin
                    n_stat = ST_OK;
                    n_vo   = 32'(r_hoff[0]);
                    n_io   = 32'(r_hoff[1]);
                    n_st   = S_FIN;
                end
            end
            S_FINIT: begin
                w_a    = r_at[r_pool];
                w_b    = r_bytes[r_pool];
                n_moff = r_at[r_pool];
                n_msz  = r_bytes[r_pool];
                n_mend = w_res;
                n_i    = '0;
                if (!r_chk) begin
                    n_st = S_MSCAN;
                end else if (w_cnt == CW'(N)) begin
                    n_st = S_FCHK;
                end else if (!r_pool) begin
                    n_pool = 1'b1;
                end else begin
                    n_pool = 1'b0;
                    n_chk  = 1'b0;
                end
            end
            S_FCHK: begin
                // A full list can take the region only if a merge frees a slot.
                w_a = w_roff;
                w_b = w_rsz;
                if (w_touch) begin
                    n_pv = 1'b0;
                    n_st = S_FINIT;
                    if (!r_pool) begin
                        n_pool = 1'b1;
                    end else begin
                        n_pool = 1'b0;
                        n_chk  = 1'b0;
                    end
                end else if (w_done) begin
                    n_stat = ST_FULL;
                    n_st   = S_FIN;
                end
            end
            S_MSCAN: begin
                w_a = w_roff;
                w_b = w_rsz;
                if (w_touch) begin
                    n_left         = (w_res == r_moff);
                    n_eoff         = w_roff;
                    n_esz          = w_rsz;
                    n_hidx[r_pool] = r_pi;
                    n_pv           = 1'b0;
                    n_st           = S_MRG;
                end else if (w_done) begin
                    n_st = S_MAPP;
                end
            end
            S_MRG: begin
                w_a   = r_msz;
                w_b   = r_esz;
                n_msz = w_res;
                if (r_left) begin
                    n_moff = r_eoff;
                end
                n_st = S_MEND;
            end
            S_MEND: begin
                w_a    = r_moff;
                w_b    = r_msz;
                n_mend = w_res;
                n_i    = CW'(r_hidx[r_pool]) + CW'(1);
                n_st   = S_DROP;
            end
            S_MAPP: begin
                w_we          = 1'b1;
                w_waddr       = {r_pool, w_cnt[IW-1:0]};
                w_wdata       = {r_moff, r_msz};
                n_cnt[r_pool] = w_cnt + CW'(1);
                if (!r_pool) begin
                    n_pool = 1'b1;
                    n_st   = S_FINIT;
                end else begin
                    n_stat = ST_OK;
                    n_st   = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_ostat = r_stat;
                    n_ovo   = r_vo;
                    n_oio   = r_io;
                    n_st    = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_INIT0;
            r_pool <= 1'b0;
            r_chk  <= 1'b0;
            r_cnt  <= '{CW'(1), CW'(1)};
            r_i    <= '0;
            r_pv   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_pool <= n_pool;
            r_chk  <= n_chk;
            r_cnt  <= n_cnt;
            r_i    <= n_i;
            r_pv   <= n_pv;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_bytes <= n_bytes;
        r_at    <= n_at;
        r_hidx  <= n_hidx;
        r_hoff  <= n_hoff;
        r_rem   <= n_rem;
        r_pi    <= n_pi;
        r_moff  <= n_moff;
        r_msz   <= n_msz;
        r_mend  <= n_mend;
        r_eoff  <= n_eoff;
        r_esz   <= n_esz;
        r_left  <= n_left;
        r_stat  <= n_stat;
        r_vo    <= n_vo;
        r_io    <= n_io;
        r_ostat <= n_ostat;
        r_ovo   <= n_ovo;
        r_oio   <= n_oio;
    end

    `AFA_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt[0] <= CW'(N) && r_cnt[1] <= CW'(N))
    `AFA_ASSERT(a_acc_busy, i_clk, i_rst_n, w_in_acc |=> r_st != S_IDLE)
    `AFA_NEVER(a_pv_range, i_clk, i_rst_n, r_pv && (CW'(r_pi) >= w_cnt))
    `AFA_ASSERT(a_err_zero, i_clk, i_rst_n, o_out_valid && o_status != ST_OK |-> o_vertex_offset == '0 && o_index_offset == '0)

endmodule
`default_nettype wire

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for the dual pool first-fit allocator.
// A predictor keeps its own copy of both free lists and works out the status
// and granted offsets of every accepted request. Each returned result is
// checked in order against it. Directed tests cover the pool extremes,
// zero-size requests, missing room, wrapped addresses and a full free list.
// They are followed by random allocate and free traffic under several
// idling and output stall patterns.
// ---------------------------------------------------------------------------
`default_nettype none
module tb
    import afa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NSLOTS       = 64;
    localparam int  SETTLE       = 20000;
    localparam int  CYCLE_LIMIT  = 20000000;
    localparam logic FUNC_RELEASE = ~FUNC_ALLOC;

    typedef struct packed {
        logic [NSLOTS-1:0][31:0] off;
        logic [NSLOTS-1:0][31:0] sz;
        logic [7:0]              cnt;
    } t_freelist;

    typedef struct packed {
        t_status     status;
        logic [31:0] voff;
        logic [31:0] ioff;
    } t_grant;

    typedef struct packed {
        logic [31:0] voff;
        logic [31:0] vsz;
        logic [31:0] ioff;
        logic [31:0] isz;
    } t_region;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_func = 1'b0;
    logic [31:0] i_vertex_bytes = '0;
    logic [31:0] i_index_bytes = '0;
    logic [31:0] i_vertex_free_at = '0;
    logic [31:0] i_index_free_at = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_status     o_status;
    logic [31:0] o_vertex_offset;
    logic [31:0] o_index_offset;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    t_freelist vlist, ilist;
    t_grant    grants_due[$];
    t_region   live_regions[$];
    int        n_errors = 0;
    int        n_cycles = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;

    dual_pool_first_fit_allocator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_vertex_bytes  (i_vertex_bytes),
        .i_index_bytes   (i_index_bytes),
        .i_vertex_free_at(i_vertex_free_at),
        .i_index_free_at (i_index_free_at),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_vertex_offset (o_vertex_offset),
        .o_index_offset  (o_index_offset),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ---------------- free list predictor ----------------

    function automatic t_freelist list_init(logic [31:0] size);
        t_freelist l;
        l = '0;
        l.sz[0] = size;
        l.cnt = 8'd1;
        return l;
    endfunction

    function automatic t_freelist list_remove(t_freelist l, int idx);
        for (int j = idx; j < int'(l.cnt) - 1; j++) begin
            l.off[j] = l.off[j+1];
            l.sz[j] = l.sz[j+1];
        end
        l.cnt = l.cnt - 8'd1;
        return l;
    endfunction

    function automatic int first_fit(t_freelist l, logic [31:0] bytes);
        for (int j = 0; j < int'(l.cnt); j++) begin
            if (l.sz[j] >= bytes) return j;
        end
        return -1;
    endfunction

    function automatic t_freelist carve(t_freelist l, int idx, logic [31:0] bytes);
        logic [31:0] rest_off;
        logic [31:0] rest_sz;
        rest_off = l.off[idx] + bytes;
        rest_sz = l.sz[idx] - bytes;
        l = list_remove(l, idx);
        if (rest_sz != 0) begin
            l.off[l.cnt] = rest_off;
            l.sz[l.cnt] = rest_sz;
            l.cnt = l.cnt + 8'd1;
        end
        return l;
    endfunction

    // Absorbs every touching neighbour, one at a time in list order.
    function automatic t_freelist coalesce(t_freelist l, logic [31:0] off,
                                           logic [31:0] sz, output bit fits);
        bit again;
        bit lft, rgt;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            for (int j = 0; j < int'(l.cnt); j++) begin
                lft = (l.off[j] + l.sz[j]) == off;
                rgt = (off + sz) == l.off[j];
                if (lft || rgt) begin
                    if (lft) off = l.off[j];
                    sz = sz + l.sz[j];
                    l = list_remove(l, j);
                    again = 1'b1;
                    break;
                end
            end
        end
        fits = int'(l.cnt) < NSLOTS;
        if (fits) begin
            l.off[l.cnt] = off;
            l.sz[l.cnt] = sz;
            l.cnt = l.cnt + 8'd1;
        end
        return l;
    endfunction

    function automatic t_grant serve_request(logic func, logic [31:0] vb, logic [31:0] ib,
                                             logic [31:0] vat, logic [31:0] iat);
        t_grant    g;
        t_freelist vn, in_;
        int        vi, ii;
        bit        vok, iok;
        g = '{status: ST_OK, voff: '0, ioff: '0};
        if (vb == 0 || ib == 0) begin
            g.status = ST_ZERO;
        end else if (func == FUNC_ALLOC) begin
            vi = first_fit(vlist, vb);
            ii = first_fit(ilist, ib);
            if (vi < 0 || ii < 0) begin
                g.status = ST_NOSPACE;
            end else begin
                g.voff = vlist.off[vi];
                g.ioff = ilist.off[ii];
                vlist = carve(vlist, vi, vb);
                ilist = carve(ilist, ii, ib);
            end
        end else begin
            vn = coalesce(vlist, vat, vb, vok);
            in_ = coalesce(ilist, iat, ib, iok);
            if (vok && iok) begin
                vlist = vn;
                ilist = in_;
            end else begin
                g.status = ST_FULL;
            end
        end
        return g;
    endfunction

    // ---------------- driving ----------------

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if (n_cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Valid is left high after acceptance; the next request or idle step decides.
    task automatic send_req(logic func, logic [31:0] vb, logic [31:0] ib,
                            logic [31:0] vat, logic [31:0] iat);
        t_grant  g;
        t_region r;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_vertex_bytes <= vb;
        i_index_bytes <= ib;
        i_vertex_free_at <= vat;
        i_index_free_at <= iat;
        do @(posedge i_clk); while (o_in_stall);
        g = serve_request(func, vb, ib, vat, iat);
        grants_due.insert(grants_due.size(), g);
        if (func == FUNC_ALLOC && g.status == ST_OK) begin
            r = '{g.voff, vb, g.ioff, ib};
            live_regions.insert(live_regions.size(), r);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (grants_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_VPOOL) vlist = list_init(value);
        else ilist = list_init(value);
        live_regions.delete();
    endtask

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (grants_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result: status %0d", o_status);
            end else begin
                g = grants_due.pop_front();
                if (o_status !== g.status || o_vertex_offset !== g.voff
                        || o_index_offset !== g.ioff) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected %0d %h %h, got %0d %h %h",
                                 g.status, g.voff, g.ioff,
                                 o_status, o_vertex_offset, o_index_offset);
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_reset_pools();
        send_req(FUNC_ALLOC, VPOOL_RESET, IPOOL_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(FUNC_ALLOC, 32'd1, 32'd1, '0, '0);
        send_req(FUNC_RELEASE, VPOOL_RESET, IPOOL_RESET, '0, '0);
        send_req(FUNC_ALLOC, 32'd100, 32'd16, '0, '0);
        send_req(FUNC_ALLOC, 32'd28, 32'd48, '0, '0);
        send_req(FUNC_RELEASE, 32'd100, 32'd16, '0, '0);
        send_req(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd1, '0, '0);
    endtask

    task automatic test_zero_size();
        send_req(FUNC_ALLOC, 32'd0, 32'd5, '0, '0);
        send_req(FUNC_ALLOC, 32'd5, 32'd0, '0, '0);
        send_req(FUNC_RELEASE, 32'd0, 32'd8, 32'd128, 32'd64);
        send_req(FUNC_RELEASE, 32'd8, 32'd0, 32'd128, 32'd64);
    endtask

    task automatic test_pool_extremes();
        write_reg(CFG_VPOOL, 32'hFFFF_FFFF);
        write_reg(CFG_IPOOL, 32'd1);
        send_req(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd1, '0, '0);
        send_req(FUNC_ALLOC, 32'd1, 32'd1, '0, '0);
        // Freed regions that wrap past the top of the address space.
        send_req(FUNC_RELEASE, 32'h20, 32'h1, 32'hFFFF_FFF0, 32'd0);
        send_req(FUNC_RELEASE, 32'h10, 32'h2, 32'h10, 32'hFFFF_FFFF);
        write_reg(CFG_VPOOL, 32'd0);
        send_req(FUNC_ALLOC, 32'd1, 32'd1, '0, '0);
        send_req(FUNC_RELEASE, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF, 32'h5555_5555);
        write_reg(CFG_IPOOL, 32'hAAAA_AAAA);
        send_req(FUNC_ALLOC, 32'h8000_0000, 32'hAAAA_AAAA, '0, '0);
    endtask

    // Freeing every other unit block fragments both lists until they overflow.
    task automatic test_list_overflow();
        write_reg(CFG_VPOOL, 32'd256);
        write_reg(CFG_IPOOL, 32'd256);
        for (int k = 0; k < 140; k++) send_req(FUNC_ALLOC, 32'd1, 32'd1, '0, '0);
        for (int k = 0; k < 140; k += 2)
            send_req(FUNC_RELEASE, 32'd1, 32'd1, k, k);
        drain();
    endtask

    task automatic random_traffic(int n_items, int ipct, int spct);
        t_region r;
        int      pick, roll;
        logic [31:0] vb, ib;
        write_reg(CFG_VPOOL, $urandom_range(2048, 8192));
        write_reg(CFG_IPOOL, $urandom_range(1024, 4096));
        idle_pct = ipct;
        stall_pct = spct;
        for (int k = 0; k < n_items; k++) begin
            if (k == n_items / 2) drain();
            roll = $urandom_range(99);
            if (roll < 45) begin
                vb = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(1, 256);
                ib = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(1, 128);
                send_req(FUNC_ALLOC, vb, ib, $urandom(), $urandom());
            end else if (roll < 85 && live_regions.size() != 0) begin
                pick = $urandom_range(live_regions.size() - 1);
                r = live_regions[pick];
                live_regions.delete(pick);
                send_req(FUNC_RELEASE, r.vsz, r.isz, r.voff, r.ioff);
            end else begin
                send_req(1'($urandom_range(1)), ($urandom_range(3) == 0) ? '0 : $urandom(),
                         ($urandom_range(3) == 0) ? '0 : $urandom(),
                         $urandom(), $urandom());
            end
        end
        drain();
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        vlist = list_init(VPOOL_RESET);
        ilist = list_init(IPOOL_RESET);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_pools();
        test_zero_size();
        test_pool_extremes();
        test_list_overflow();
        random_traffic(80, 0, 0);
        random_traffic(80, 47, 0);
        random_traffic(80, 0, 47);
        random_traffic(80, 30, 30);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (n_errors == 0 && grants_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
